[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the stock span stream
// Field widths, day saturation limit, stack entry and cell shift command.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned PriceWidth        = 31;
  localparam int unsigned DayWidth          = 32;
  localparam int unsigned StackDepthDefault = 64;

  // Day counter freezes one below all-ones.
  localparam logic [DayWidth-1:0] DayLimit = {{(DayWidth-1){1'b1}}, 1'b0};

  typedef logic [PriceWidth-1:0] price_t;
  typedef logic [DayWidth-1:0]   day_t;

  typedef struct packed {
    day_t   day;
    price_t price;
  } entry_t;

  // Row-wide shift command: push moves every entry one cell deeper,
  // pop moves every entry one cell toward the top.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

[rtl/ssp_if.sv]
// ----------------------------------------------------------------------------
// ssp_if: valid/ready channels of the stock span stream
// Input channel carries one price word, output channel one span word.
// ----------------------------------------------------------------------------
interface ssp_in_if import ssp_pkg::*;;
  logic   valid;
  logic   ready;
  price_t price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface ssp_out_if import ssp_pkg::*;;
  logic valid;
  logic ready;
  day_t span;
  logic stack_overflow;

  modport source (output valid, output span, output stack_overflow, input ready);
  modport sink   (input valid, input span, input stack_overflow, output ready);
endinterface

[rtl/ssp_cell.sv]
// ----------------------------------------------------------------------------
// ssp_cell: one stack slot of the span chain
// Holds a (day, price) pair; takes the neighbor above on push, below on pop.
// ----------------------------------------------------------------------------
module ssp_cell import ssp_pkg::*; (
  input  logic   clk_i,
  input  shift_t shift_i,
  input  entry_t above_i,
  input  entry_t below_i,
  output entry_t entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (shift_i.push) begin
      entry_d = above_i;
    end else if (shift_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/ssp_chain.sv]
// ----------------------------------------------------------------------------
// ssp_chain: row of stack cells, top of stack in cell 0
// Push inserts a new entry at the top; pop drops the top entry.
// ----------------------------------------------------------------------------
module ssp_chain import ssp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic   clk_i,
  input  shift_t shift_i,
  input  entry_t new_i,
  output entry_t top_o
);

  entry_t row [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t above, below;

    if (i == 0) begin : g_top
      assign above = new_i;
    end else begin : g_mid_a
      assign above = row[i-1];
    end

    // The bottom cell refills from itself on pop; that slot is past the count.
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = row[i];
    end else begin : g_mid_b
      assign below = row[i+1];
    end

    ssp_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .above_i (above),
      .below_i (below),
      .entry_o (row[i])
    );
  end

  assign top_o = row[0];

endmodule

[rtl/stock_span_stream.sv]
// Each accepted word pops its covered entries one at a time, then pushes once the
// output register has room; each entry pops at most once.
// Pops go through the single top-of-stack compare in cell 0, one pop per cycle.
// Reset clears the busy flag, entry count, day counter and output valid; cell storage
// is not cleared and needs no clearing pass, since only entries below the count are read.
// ----------------------------------------------------------------------------
// stock_span_stream: online stock span over a stream of prices
// Monotonic stack kept in a chain of cells with a decreasing-price invariant.
// ----------------------------------------------------------------------------
module stock_span_stream import ssp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  ssp_in_if.sink     in_i,
  ssp_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(STACK_DEPTH);

  // Item under work
  logic   busy_q, busy_d;
  price_t price_q, price_d;

  // Stack fill and day numbering
  logic [CntW-1:0] count_q, count_d;
  day_t            day_q, day_d;

  // Output word register
  logic out_valid_q, out_valid_d;
  day_t span_q, span_d;
  logic ovf_q, ovf_d;

  shift_t shift;
  entry_t top;
  entry_t new_entry;
  logic   stack_empty, stack_full;
  logic   top_le, out_free;
  day_t   diff;

  ssp_chain #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_chain (
    .clk_i   (clk_i),
    .shift_i (shift),
    .new_i   (new_entry),
    .top_o   (top)
  );

  assign stack_empty = (count_q == '0);
  assign stack_full  = (count_q == DepthCnt);
  assign top_le      = (top.price <= price_q);
  assign out_free    = !out_valid_q || out_o.ready;

  // Pop while the top entry does not exceed the price; then push once the
  // output register has room.
  always_comb begin
    shift.pop  = busy_q && !stack_empty && top_le;
    shift.push = busy_q && !shift.pop && out_free;
  end

  assign new_entry.day   = day_q;
  assign new_entry.price = price_q;

  assign diff = day_q - top.day;

  // Accept a new word while idle, or in the cycle the current one retires.
  assign in_i.ready = !busy_q || shift.push;

  always_comb begin
    busy_d      = busy_q;
    price_d     = price_q;
    count_d     = count_q;
    day_d       = day_q;
    out_valid_d = out_valid_q;
    span_d      = span_q;
    ovf_d       = ovf_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (shift.pop) begin
      count_d = count_q - CntW'(1);
    end

    if (shift.push) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      ovf_d       = stack_full;
      if (stack_empty) begin
        span_d = day_q + DayWidth'(1);
      end else if (diff == '0) begin
        // Frozen day counter: clamp to one
        span_d = DayWidth'(1);
      end else begin
        span_d = diff;
      end
      // Full stack drops its bottom entry, so the count holds
      if (!stack_full) begin
        count_d = count_q + CntW'(1);
      end
      if (day_q != DayLimit) begin
        day_d = day_q + DayWidth'(1);
      end
    end

    if (in_i.valid && in_i.ready) begin
      busy_d  = 1'b1;
      price_d = in_i.price;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      day_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      day_q       <= day_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    span_q  <= span_d;
    ovf_q   <= ovf_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.span           = span_q;
  assign out_o.stack_overflow = ovf_q;

`ifndef NO_ASSERTIONS
  // Stack fill never passes the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("stack count exceeds depth");

  // Push onto a full stack flags overflow on that word's output span
  a_ovf_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift.push && stack_full) |=> (out_valid_q && ovf_q))
    else $error("full push did not flag overflow");

  // A push always leaves at least one entry
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift.push |=> (count_q != '0))
    else $error("stack empty after push");

  // A presented span is never zero
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (span_q != '0))
    else $error("zero span presented");
`endif

endmodule
